FILE: sv/sstv_pkg.sv
// ----------------------------------------------------------------------------
// SSTV tone synthesizer package
// Shared types, register codes, reset values and elaboration-time table
// builders for the sine quarter wave and the yuv level map.
// ----------------------------------------------------------------------------
package sstv_pkg;

    localparam int AMP_W    = 15;
    localparam int STEP_W   = 24;
    localparam int PERIOD_W = 20;
    localparam int FREQ_W   = 12;
    localparam int LEVEL_W  = 8;
    localparam int DUR_W    = 29;
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_ADDR_W = 2;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [AMP_W-1:0]    AMP_RESET    = 15'd6553;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 24'd389566;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd92880;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        ACT_LOAD_FREQ  = 2'd0,
        ACT_LOAD_LEVEL = 2'd1,
        ACT_TICK       = 2'd2
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AMPLITUDE   = 2'd0,
        REG_STEP_PER_HZ = 2'd1,
        REG_PERIOD      = 2'd2,
        REG_LEVEL_MAP   = 2'd3
    } cfg_reg_t;

    // control part of one queued request
    typedef struct packed {
        logic is_tick;
        logic silent;
    } qctl_t;

    // Quarter-wave sine magnitude, integer Taylor series in Q30, rounded
    // to frac_bits and clamped to one.
    function automatic logic [20:0] quarter_sine(input int r, input int addr_bits,
                                                 input int frac_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        x    = (64'(r) * HALF_PI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                7: term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
        if (v > (longint'(1) <<< frac_bits)) begin
            v = longint'(1) <<< frac_bits;
        end
        return 21'(v);
    endfunction

    // yuv level map: 1500 + floor(800c/255), one less at nonzero multiples of 51
    function automatic logic [FREQ_W-1:0] level_freq_yuv(input int c);
        int f;
        f = 1500 + (800 * c) / 255;
        if (c != 0 && (c % 51) == 0) begin
            f = f - 1;
        end
        return 12'(f);
    endfunction

endpackage

FILE: sv/sstv_front.sv
// ----------------------------------------------------------------------------
// SSTV front end
// Registers incoming requests, maps levels to frequencies, forms the phase
// step of each load and pushes loads and ticks into the request queue.
// ----------------------------------------------------------------------------
module sstv_front #(
    parameter int PHASE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [55:0]                     s_tdata,   // frequency, level, duration
    input  logic [1:0]                      s_tuser,   // action
    input  logic [sstv_pkg::STEP_W-1:0]     step_per_hz,
    input  logic                            level_map,
    input  logic                            q_full,
    output logic                            q_push,
    output sstv_pkg::qctl_t                 q_ctl,
    output logic [sstv_pkg::DUR_W-1:0]      q_duration,
    output logic [PHASE_BITS-1:0]           q_step
);
    import sstv_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    action_t              action_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [DUR_W-1:0]     dur_reg;

    logic [FREQ_W-1:0]    yuv_tab [256];
    logic [17:0]          rgb_prod;
    logic [FREQ_W-1:0]    freq_rgb;
    logic [FREQ_W-1:0]    freq_sel;
    logic [35:0]          step_prod;
    logic                 is_tick;
    logic                 is_load;
    logic                 stage_free;

    for (genvar i = 0; i < 256; i++) begin : g_yuv
        localparam logic [FREQ_W-1:0] FV = level_freq_yuv(i);
        assign yuv_tab[i] = FV;
    end

    always_comb begin
        is_tick = 1'b0;
        is_load = 1'b0;
        case (action_reg)
            ACT_LOAD_FREQ:  is_load = 1'b1;
            ACT_LOAD_LEVEL: is_load = 1'b1;
            ACT_TICK:       is_tick = 1'b1;
            default: ;
        endcase
    end

    assign rgb_prod = 18'(level_reg) * 18'd800;
    assign freq_rgb = 12'd1500 + {2'b00, rgb_prod[17:8]};

    always_comb begin
        if (action_reg == ACT_LOAD_FREQ) begin
            freq_sel = freq_reg;
        end else if (level_map) begin
            freq_sel = yuv_tab[level_reg];
        end else begin
            freq_sel = freq_rgb;
        end
    end

    assign step_prod = 36'(freq_sel) * 36'(step_per_hz);

    // drop unknown actions without touching the queue
    assign stage_free = !valid_reg || !(is_tick || is_load) || !q_full;
    assign s_tready   = stage_free;
    assign q_push     = valid_reg && (is_tick || is_load) && !q_full;

    assign q_ctl.is_tick = is_tick;
    assign q_ctl.silent  = (freq_sel == '0);
    assign q_duration    = dur_reg;
    assign q_step        = PHASE_BITS'(step_prod);

    assign valid_next = stage_free ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_free && s_tvalid) begin
            action_reg <= action_t'(s_tuser);
            freq_reg   <= s_tdata[11:0];
            level_reg  <= s_tdata[19:12];
            dur_reg    <= s_tdata[48:20];
        end
    end

endmodule

FILE: sv/sstv_queue.sv
// ----------------------------------------------------------------------------
// SSTV request queue
// Short register FIFO between the front end and the tone engine.
// ----------------------------------------------------------------------------
module sstv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty,
    output logic             full
);
    import sstv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue read while empty");

endmodule

FILE: sv/sstv_back.sv
// ----------------------------------------------------------------------------
// SSTV tone engine
// Holds phase, time remainder and tone step; executes loads and ticks and
// runs the sine lookup, amplitude scale and output register pipeline.
// ----------------------------------------------------------------------------
module sstv_back #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  sstv_pkg::qctl_t               q_ctl,
    input  logic [sstv_pkg::DUR_W-1:0]    q_duration,
    input  logic [PHASE_BITS-1:0]         q_step,
    input  logic [sstv_pkg::AMP_W-1:0]    amplitude,
    input  logic [sstv_pkg::PERIOD_W-1:0] sample_period,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // sample
    output logic                          m_tlast
);
    import sstv_pkg::*;

    localparam int QLEN  = 1 << (SINE_ADDR_BITS - 2);
    localparam int R_W   = SINE_ADDR_BITS - 1;
    localparam int PROD_W = SINE_FRAC_BITS + 1 + AMP_W;

    // tone state
    logic [PHASE_BITS-1:0]    phase_reg, phase_next;
    logic signed [TIME_W-1:0] tl_reg, tl_next;
    logic [PHASE_BITS-1:0]    step_reg, step_next;
    logic                     silent_reg, silent_next;

    // pipeline
    logic                     v1_reg, v2_reg, out_valid_reg;
    logic                     silent1_reg, neg1_reg, neg2_reg, done2_reg, last_reg;
    logic [R_W-1:0]           r1_reg;
    logic signed [TIME_W-1:0] tl1_reg;
    logic [SINE_FRAC_BITS:0]  qs2_reg;
    logic [SAMPLE_W-1:0]      sample_reg;

    logic                     advance;
    logic                     exec_tick, exec_load, can_emit, emit;
    logic signed [TIME_W:0]   period_ext, twice_tl, twice_tl1, tl_sub, tl_add;
    logic signed [TIME_W-1:0] tl_sub_sat, tl_add_sat;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [R_W-1:0]           r_fold;
    logic [SINE_FRAC_BITS:0]  sine_rom [QLEN+1];
    logic [PROD_W-1:0]        prod;
    logic [AMP_W-1:0]         mag;
    logic [SAMPLE_W-1:0]      sample_next;

    for (genvar i = 0; i <= QLEN; i++) begin : g_rom
        localparam logic [20:0] QV = quarter_sine(i, SINE_ADDR_BITS, SINE_FRAC_BITS);
        assign sine_rom[i] = QV[SINE_FRAC_BITS:0];
    end

    // whole pipeline holds while a result waits
    assign advance   = !out_valid_reg || m_tready;
    assign q_pop     = q_valid && advance;
    assign exec_tick = q_pop && q_ctl.is_tick;
    assign exec_load = q_pop && !q_ctl.is_tick;

    assign period_ext = {13'd0, sample_period};
    assign twice_tl   = {tl_reg, 1'b0};
    assign can_emit   = (twice_tl >= period_ext);
    assign emit       = exec_tick && can_emit;

    assign tl_sub     = {tl_reg[TIME_W-1], tl_reg} - period_ext;
    assign tl_sub_sat = (tl_sub[TIME_W] && !tl_sub[TIME_W-1]) ?
                        {1'b1, {(TIME_W-1){1'b0}}} : tl_sub[TIME_W-1:0];
    assign tl_add     = {tl_reg[TIME_W-1], tl_reg} + {4'd0, q_duration};
    assign tl_add_sat = (!tl_add[TIME_W] && tl_add[TIME_W-1]) ?
                        {1'b0, {(TIME_W-1){1'b1}}} : tl_add[TIME_W-1:0];

    assign idx    = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign r_fold = idx[SINE_ADDR_BITS-2] ?
                    R_W'(QLEN) - {1'b0, idx[SINE_ADDR_BITS-3:0]} :
                    {1'b0, idx[SINE_ADDR_BITS-3:0]};

    always_comb begin
        phase_next  = phase_reg;
        tl_next     = tl_reg;
        step_next   = step_reg;
        silent_next = silent_reg;
        if (exec_load) begin
            tl_next     = tl_add_sat;
            step_next   = q_step;
            silent_next = q_ctl.silent;
        end else if (emit) begin
            tl_next = tl_sub_sat;
            if (!silent_reg) begin
                phase_next = phase_reg + step_reg;
            end
        end
    end

    assign twice_tl1   = {tl1_reg, 1'b0};
    assign prod        = PROD_W'(qs2_reg) * PROD_W'(amplitude);
    assign mag         = prod[SINE_FRAC_BITS +: AMP_W];
    assign sample_next = neg2_reg ? SAMPLE_W'(-{1'b0, mag}) : {1'b0, mag};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            tl_reg        <= '0;
            step_reg      <= '0;
            silent_reg    <= 1'b1;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            tl_reg     <= tl_next;
            step_reg   <= step_next;
            silent_reg <= silent_next;
            if (advance) begin
                v1_reg        <= emit;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            silent1_reg <= silent_reg;
            neg1_reg    <= idx[SINE_ADDR_BITS-1];
            r1_reg      <= r_fold;
            tl1_reg     <= tl_next;
            qs2_reg     <= silent1_reg ? '0 : sine_rom[r1_reg];
            neg2_reg    <= neg1_reg;
            done2_reg   <= (twice_tl1 < period_ext);
            sample_reg  <= sample_next;
            last_reg    <= done2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sample_reg;
    assign m_tlast  = last_reg;

    a_stall_freezes_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg) && $stable(tl_reg) && $stable(qs2_reg))
        else $error("tone state moved during output stall");

    a_silent_holds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_tick && silent_reg |=> $stable(phase_reg))
        else $error("phase advanced while silent");

    a_load_never_lowers_time: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_load |=> tl_reg >= $past(tl_reg))
        else $error("load reduced time remainder");

endmodule

FILE: sv/sstv_tone_synthesizer_core.sv
// ----------------------------------------------------------------------------
// SSTV tone synthesizer core
// Phase-continuous tone generator: loads set frequency and add duration,
// ticks emit sine samples while time remains.
// ----------------------------------------------------------------------------
// Path: front register, request queue, then engine stages v1, v2 and output.
// Throughput: one request per cycle while the output is not stalled; loads and
// ticks both issue back to back, paced by the phase and time-remainder update.
// Reset: clears pipeline valids and queue, phase, remainder and tone step,
// sets silence and loads register defaults. Output stalls hold the engine.
module sstv_tone_synthesizer_core #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sstv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sstv_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [55:0]                       s_tdata,  // frequency[11:0], level[19:12],
                                                        // duration[48:20]
    input  logic [1:0]                        s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // sample
    output logic                              m_tlast   // tone_done
);
    import sstv_pkg::*;

    localparam int Q_W = PHASE_BITS + DUR_W + $bits(qctl_t);

    logic [AMP_W-1:0]    amp_reg;
    logic [STEP_W-1:0]   step_hz_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                level_map_reg;

    logic                q_push, q_pop, q_full, q_not_empty;
    qctl_t               f_ctl, b_ctl;
    logic [DUR_W-1:0]    f_dur;
    logic [PHASE_BITS-1:0] f_step;
    logic [Q_W-1:0]      q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg       <= AMP_RESET;
            step_hz_reg   <= STEP_RESET;
            period_reg    <= PERIOD_RESET;
            level_map_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_AMPLITUDE:   amp_reg       <= cfg_wr_data[AMP_W-1:0];
                REG_STEP_PER_HZ: step_hz_reg   <= cfg_wr_data[STEP_W-1:0];
                REG_PERIOD:      period_reg    <= cfg_wr_data[PERIOD_W-1:0];
                REG_LEVEL_MAP:   level_map_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    sstv_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .step_per_hz (step_hz_reg),
        .level_map   (level_map_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ctl       (f_ctl),
        .q_duration  (f_dur),
        .q_step      (f_step)
    );

    assign q_wdata = {f_step, f_dur, f_ctl};

    sstv_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign b_ctl = qctl_t'(q_rdata[$bits(qctl_t)-1:0]);

    sstv_back #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_pop         (q_pop),
        .q_ctl         (b_ctl),
        .q_duration    (q_rdata[$bits(qctl_t) +: DUR_W]),
        .q_step        (q_rdata[Q_W-1 -: PHASE_BITS]),
        .amplitude     (amp_reg),
        .sample_period (period_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

FILE: tb/sv/sstv_tone_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSTV tone synthesizer checker
// Watches the register port and both stream channels. It tracks phase, time
// remainder and tone settings, predicts every sample that a tick produces,
// and compares the samples that come out against those predictions in order.
// ----------------------------------------------------------------------------
module sstv_tone_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sstv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sstv_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [55:0]                       s_tdata,  // frequency[11:0], level[19:12],
                                                        // duration[48:20]
    input  logic [1:0]                        s_tuser,  // action
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [15:0]                       m_tdata,  // sample
    input  logic                              m_tlast,  // tone_done
    output int                                fail_count,
    output int                                pending,
    output int                                samples_checked
);
    import sstv_pkg::*;

    localparam int     ADDR_BITS = 10;
    localparam int     FRAC_BITS = 15;
    localparam longint REM_MAX   = 64'sd2147483647;
    localparam longint REM_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] sample;
    } tone_sample_t;

    longint              sine_rom [0:256];

    logic [AMP_W-1:0]    amp_r;
    logic [STEP_W-1:0]   step_hz_r;
    logic [PERIOD_W-1:0] period_r;
    logic                yuv_r;

    logic [31:0]         phase_acc;
    longint              time_rem;
    logic [31:0]         tone_inc;
    logic                tone_silent;

    tone_sample_t        sample_q [$];
    int                  mismatches = 0;
    int                  checked = 0;

    // Quarter-wave magnitude in Q15: Taylor series in Q30 radians, nine terms.
    function automatic longint taylor_sine_q15(input int r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          v;
        int              k;
        x    = (64'(r) * 64'd1686629713) >> (ADDR_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (v > (64'sd1 <<< FRAC_BITS)) begin
            v = 64'sd1 <<< FRAC_BITS;
        end
        return v;
    endfunction

    function automatic logic [FREQ_W-1:0] level_hz(input logic [LEVEL_W-1:0] c,
                                                   input logic yuv);
        int cv;
        int f;
        cv = c;
        if (yuv) begin
            f = 1500 + (800 * cv) / 255;
            // the yuv scale lands one high on nonzero multiples of 51
            if (cv != 0 && cv % 51 == 0) begin
                f = f - 1;
            end
        end else begin
            f = 1500 + ((800 * cv) >> 8);
        end
        return f[FREQ_W-1:0];
    endfunction

    function automatic void load_tone(input logic [FREQ_W-1:0] hz,
                                      input logic [DUR_W-1:0] dur);
        longint                   t;
        longint                   dl;
        logic [STEP_W+FREQ_W-1:0] prod;
        dl = dur;
        t  = time_rem + dl;
        if (t > REM_MAX) begin
            t = REM_MAX;
        end
        time_rem    = t;
        tone_silent = (hz == 0);
        prod        = step_hz_r * hz;
        tone_inc    = prod[31:0];
    endfunction

    // Returns 1 with the predicted sample when the tick has enough time left.
    function automatic bit tick_sample(output tone_sample_t res);
        longint     per;
        logic [9:0] idx;
        int         r;
        longint     mag;
        longint     s;
        per = period_r;
        res = '0;
        if (2 * time_rem < per) begin
            return 1'b0;
        end
        s = 0;
        if (!tone_silent) begin
            idx = phase_acc[31:32-ADDR_BITS];
            r   = idx[ADDR_BITS-3:0];
            // mirror odd quadrants, negate the lower half wave
            if (idx[ADDR_BITS-2]) begin
                r = (1 << (ADDR_BITS - 2)) - r;
            end
            mag = (sine_rom[r] * longint'(amp_r)) >>> FRAC_BITS;
            s   = idx[ADDR_BITS-1] ? -mag : mag;
            phase_acc = phase_acc + tone_inc;
        end
        time_rem = time_rem - per;
        if (time_rem < REM_MIN) begin
            time_rem = REM_MIN;
        end
        res.sample = s[SAMPLE_W-1:0];
        res.done   = (2 * time_rem < per);
        return 1'b1;
    endfunction

    initial begin : build_rom
        int i;
        for (i = 0; i <= 256; i++) begin
            sine_rom[i] = taylor_sine_q15(i);
        end
    end

    always @(posedge aclk) begin : watch
        tone_sample_t want;
        if (!aresetn) begin
            amp_r       = AMP_RESET;
            step_hz_r   = STEP_RESET;
            period_r    = PERIOD_RESET;
            yuv_r       = 1'b0;
            phase_acc   = '0;
            time_rem    = 0;
            tone_inc    = '0;
            tone_silent = 1'b1;
            sample_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_AMPLITUDE:   amp_r     = cfg_wr_data[AMP_W-1:0];
                    REG_STEP_PER_HZ: step_hz_r = cfg_wr_data[STEP_W-1:0];
                    REG_PERIOD:      period_r  = cfg_wr_data[PERIOD_W-1:0];
                    REG_LEVEL_MAP:   yuv_r     = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_LOAD_FREQ: begin
                        load_tone(s_tdata[11:0], s_tdata[48:20]);
                    end
                    ACT_LOAD_LEVEL: begin
                        load_tone(level_hz(s_tdata[19:12], yuv_r), s_tdata[48:20]);
                    end
                    ACT_TICK: begin
                        if (tick_sample(want)) begin
                            sample_q.push_back(want);
                        end
                    end
                    default: ;  // drop reserved action
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (sample_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected sample: expected none, actual %0d done %0b",
                             $time, $signed(m_tdata), m_tlast);
                end else begin
                    want = sample_q.pop_front();
                    checked++;
                    if (m_tdata !== want.sample) begin
                        mismatches++;
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.sample), $signed(m_tdata));
                    end
                    if (m_tlast !== want.done) begin
                        mismatches++;
                        $display("%0t: tone_done mismatch: expected %0b, actual %0b",
                                 $time, want.done, m_tlast);
                    end
                end
            end
        end
        pending         <= sample_q.size();
        fail_count      <= mismatches;
        samples_checked <= checked;
    end

endmodule

FILE: tb/sv/tb_sstv_tone_synthesizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSTV tone synthesizer core testbench
// Sends load and tick requests with random gaps against random output stalls,
// over several register settings from reset values to the extremes. Samples
// are predicted and compared by the checker that sits beside the core.
// ----------------------------------------------------------------------------
module tb_sstv_tone_synthesizer_core;
    import sstv_pkg::*;

    localparam logic [1:0]  ACT_RESERVED = 2'd3;
    localparam int unsigned DUR_MAX      = (1 << DUR_W) - 1;
    localparam int          P_DEF        = PERIOD_RESET;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 500000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    cfg_reg_t            cfg_addr;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [55:0]         s_tdata;   // frequency[11:0], level[19:12], duration[48:20]
    logic [1:0]          s_tuser;   // action
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;   // sample
    logic                m_tlast;   // tone_done

    int                  fail_count;
    int                  pending;
    int                  samples_checked;

    int                  cycles = 0;
    int                  n_items = 0;
    int                  n_loads = 0;
    int                  n_ticks = 0;
    int                  n_settings = 1;
    bit                  send_burst = 1'b0;
    bit                  recv_burst = 1'b0;
    logic [PERIOD_W-1:0] cur_period = PERIOD_RESET;

    sstv_tone_synthesizer_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    sstv_tone_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .samples_checked (samples_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycles);
            $display("sstv_tone_synthesizer_core regression: fail");
            $finish;
        end
    end

    // Result side: random stall before each sample, with stretches of none.
    initial begin : sink
        int stall;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                recv_burst = !recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic push_request(input logic [1:0] act, input logic [FREQ_W-1:0] hz,
                                input logic [LEVEL_W-1:0] lvl, input logic [DUR_W-1:0] dur);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 10);
        // keep valid high across back-to-back requests
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, dur, lvl, hz};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_items++;
        if (act == ACT_LOAD_FREQ || act == ACT_LOAD_LEVEL) begin
            n_loads++;
        end else if (act == ACT_TICK) begin
            n_ticks++;
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            push_request(ACT_TICK, $urandom_range(0, 4095), $urandom_range(0, 255),
                         $urandom_range(0, DUR_MAX));
        end
    endtask

    // Hold off until every sample is out, then let a trailing load settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [AMP_W-1:0] amp, input logic [STEP_W-1:0] step,
                                input logic [PERIOD_W-1:0] per, input logic yuv);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_AMPLITUDE;
        cfg_wr_data <= CFG_W'(amp);
        @(posedge aclk);
        cfg_addr    <= REG_STEP_PER_HZ;
        cfg_wr_data <= CFG_W'(step);
        @(posedge aclk);
        cfg_addr    <= REG_PERIOD;
        cfg_wr_data <= CFG_W'(per);
        @(posedge aclk);
        cfg_addr    <= REG_LEVEL_MAP;
        cfg_wr_data <= CFG_W'(yuv);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_period = per;
        n_settings++;
    endtask

    // One tone: a load sized to a few sample periods, then roughly that many ticks.
    task automatic tone_sequence();
        int                  k;
        int                  nt;
        longint              p;
        longint              d;
        logic [FREQ_W-1:0]   hz;
        logic [LEVEL_W-1:0]  lvl;
        p = cur_period;
        k = $urandom_range(0, 6);
        if (p == 0) begin
            d = $urandom_range(0, 4000);
        end else begin
            d = longint'(k) * p + longint'($urandom_range(0, p)) - p / 2;
        end
        if (d < 0) begin
            d = 0;
        end
        if (d > DUR_MAX) begin
            d = DUR_MAX;
        end
        case ($urandom_range(0, 7))
            0:       hz = '0;
            1, 2:    hz = $urandom_range(0, 4095);
            default: hz = $urandom_range(1100, 2300);
        endcase
        lvl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 5) * 51)
                                          : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
            push_request(ACT_LOAD_FREQ, hz, lvl, d);
        end else begin
            push_request(ACT_LOAD_LEVEL, $urandom_range(0, 4095), lvl, d);
        end
        nt = k + $urandom_range(0, 2) - 1;
        if (nt > 0) begin
            send_ticks(nt);
        end
    endtask

    task automatic stray_request();
        case ($urandom_range(0, 2))
            0: push_request(ACT_RESERVED, $urandom_range(0, 4095), $urandom_range(0, 255),
                            $urandom_range(0, DUR_MAX));
            1: send_ticks(1);
            default: push_request(ACT_LOAD_FREQ, $urandom_range(0, 4095),
                                  $urandom_range(0, 255),
                                  $urandom_range(0, 2 * int'(cur_period)));
        endcase
    endtask

    task automatic run_tones(input int target);
        while (n_items < target) begin
            if ($urandom_range(0, 9) == 0) begin
                stray_request();
            end else begin
                tone_sequence();
            end
        end
    endtask

    initial begin : stimulus
        int i;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_AMPLITUDE;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= ACT_TICK;
        s_tdata     <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: empty remainder, reserved action, silence, extremes
        send_ticks(1);
        push_request(ACT_RESERVED, 12'hFFF, 8'hFF, DUR_MAX);
        push_request(ACT_LOAD_FREQ, 12'd0, 8'h00, 2 * P_DEF);
        send_ticks(3);
        push_request(ACT_LOAD_FREQ, 12'hFFF, 8'hFF, 3 * P_DEF);
        send_ticks(3);
        push_request(ACT_LOAD_LEVEL, 12'd0, 8'd0, P_DEF);
        send_ticks(1);
        push_request(ACT_LOAD_LEVEL, 12'hFFF, 8'd255, 2 * P_DEF);
        send_ticks(1);
        // cut a tone short, then carry its remainder into a zero-length load
        push_request(ACT_LOAD_FREQ, 12'd1900, 8'd0, 4 * P_DEF);
        send_ticks(2);
        push_request(ACT_LOAD_FREQ, 12'd1200, 8'd0, 0);
        send_ticks(3);

        run_tones(110);
        wait_drained();
        run_tones(200);

        wait_drained();
        program_regs(15'h7FFF, 24'hFFFFFF, 20'd1, 1'b1);
        for (i = 0; i <= 5; i++) begin
            push_request(ACT_LOAD_LEVEL, 12'd0, (i == 5) ? 8'd1 : 8'(i * 51), 1);
            send_ticks(1);
        end
        run_tones(370);

        // zero step on a nonzero frequency freezes the phase but still sounds
        wait_drained();
        program_regs(15'h7FFF, 24'd0, 20'hFFFFF, 1'b0);
        run_tones(500);

        wait_drained();
        program_regs(15'd0, $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 300000), 1'b1);
        run_tones(600);

        repeat (2) begin
            wait_drained();
            program_regs($urandom_range(0, 32767), $urandom_range(0, 24'hFFFFFF),
                         $urandom_range(1, 200000), $urandom_range(0, 1));
            run_tones(n_items + 130);
        end

        // zero period: ticks emit while the remainder is not negative
        wait_drained();
        program_regs(AMP_RESET, STEP_RESET, 20'd0, 1'b0);
        run_tones(n_items + 40);

        // stack maximum durations until the remainder saturates
        wait_drained();
        program_regs(AMP_RESET, STEP_RESET, 20'hFFFFF, 1'b0);
        repeat (5) begin
            push_request(ACT_LOAD_FREQ, $urandom_range(1100, 2300), $urandom_range(0, 255),
                         DUR_MAX);
            send_ticks(2);
        end
        send_ticks(10);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests (%0d loads, %0d ticks) under %0d register settings,",
                 n_items, n_loads, n_ticks, n_settings);
        $display("%0d samples checked, with silence, carry-over, zero period and saturation.",
                 samples_checked);
        if (fail_count == 0) begin
            $display("sstv_tone_synthesizer_core regression: pass");
        end else begin
            $display("sstv_tone_synthesizer_core regression: fail");
        end
        $finish;
    end

endmodule
